// File: src/priority_round_robin_task_scheduler_unit_assert.svh
// Assertion macros for the task scheduler unit.
// Each macro checks a property on the rising edge of i_clk, idle in reset.
`ifndef PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_UNIT_ASSERT_SVH
`define PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PRRTS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// Next-cycle implication.
`define PRRTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

// File: src/prrts_pkg.sv
// ----------------------------------------------------------------------------
// prrts_pkg
// Types, constants and helpers shared by the task scheduler modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prrts_pkg;

    localparam int NUM_PRIORITIES     = 5;
    localparam int SLOTS_PER_PRIORITY = 8;
    localparam int MAX_TASKS          = 16;

    localparam int IDLE_ROW = NUM_PRIORITIES - 1;
    localparam int NSLOTS   = NUM_PRIORITIES * SLOTS_PER_PRIORITY;
    localparam int ROW_W    = $clog2(NUM_PRIORITIES);
    localparam int SLOT_W   = $clog2(SLOTS_PER_PRIORITY);
    localparam int POS_W    = $clog2(NSLOTS);
    localparam int CNT_W    = $clog2(SLOTS_PER_PRIORITY + 1);
    localparam int TASK_IW  = $clog2(MAX_TASKS);
    localparam int TC_W     = $clog2(MAX_TASKS + 1);

    localparam logic [2:0] OP_CREATE  = 3'd0;
    localparam logic [2:0] OP_BLOCK   = 3'd1;
    localparam logic [2:0] OP_UNBLOCK = 3'd2;
    localparam logic [2:0] OP_TICK    = 3'd3;
    localparam logic [2:0] OP_CONTEXT = 3'd4;

    typedef enum logic [1:0] {
        ST_EMPTY   = 2'd0,
        ST_READY   = 2'd1,
        ST_RUNNING = 2'd2,
        ST_BLOCKED = 2'd3
    } t_slot_st;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_CTX_WR,
        S_CTX_RUN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [3:0]  task_number;
        logic [2:0]  priority_req;
        logic [31:0] task_sp;
    } t_sched_in;

    typedef struct packed {
        logic [31:0] next_sp;
        logic        switch_needed;
        logic [3:0]  assigned_task;
        logic        status;
    } t_sched_out;

    typedef struct packed {
        logic load;
        logic exec;
        logic scan_rd;
        logic scan_chk;
        logic ctx_wr;
        logic ctx_run;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] opcode;
        logic       started;
        logic       scan_more;
    } t_dp_sts;

    function automatic logic [POS_W-1:0] f_pos(input logic [ROW_W-1:0] row,
                                               input logic [SLOT_W-1:0] slot);
        return POS_W'(int'(row) * SLOTS_PER_PRIORITY + int'(slot));
    endfunction

endpackage

// File: src/priority_round_robin_task_scheduler_unit.sv
// ----------------------------------------------------------------------------
// priority_round_robin_task_scheduler_unit
// Fixed-priority round-robin task scheduler with a task table.
// ----------------------------------------------------------------------------
// Usage:
//   Present an operation on i_cmd and raise start while busy is low; the
//   transaction is taken at that edge and busy stays high until the result.
//   The result appears on o_result for exactly one cycle with o_done high.
//   The receiver cannot stall; it must take the result in that cycle.
// Sequence (accepting edge to the edge that takes the result):
//   create, block, unblock, unused opcodes: S_EXEC, then S_DONE.
//   context: S_EXEC, S_CTX_WR, then S_CTX_RUN once started, then S_DONE.
//   tick: S_EXEC, S_DONE before start, else S_SCAN_RD and S_SCAN_CHK for
//   each of v (1 to SLOTS_PER_PRIORITY) slots visited by the round-robin
//   search; each visit is one registered read of the slot state memory.
//   A new transaction is accepted the cycle after o_done.
// Reset: synchronous, active low. All slots read as empty, counters clear,
//   switch flag set; stack and task tables hold no defined value until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "priority_round_robin_task_scheduler_unit_assert.svh"

module priority_round_robin_task_scheduler_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  prrts_pkg::t_sched_in  i_cmd,
    output logic                  busy,
    output logic                  o_done,
    output prrts_pkg::t_sched_out o_result
);

    prrts_pkg::t_dp_cmd dp_cmd;
    prrts_pkg::t_dp_sts dp_sts;

    // sequencer
    prrts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    // datapath
    prrts_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (dp_cmd),
        .i_item   (i_cmd),
        .o_sts    (dp_sts),
        .o_result (o_result)
    );

    // checks
    `PRRTS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `PRRTS_ASSERT_NOW(a_done_busy, o_done, busy)
    `PRRTS_ASSERT_NEXT(a_done_pulse, o_done, !o_done && !busy)

endmodule

// File: src/prrts_ctrl.sv
// ----------------------------------------------------------------------------
// prrts_ctrl
// Sequencer: steps the datapath through each operation and flags the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prrts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  prrts_pkg::t_dp_sts i_sts,
    output prrts_pkg::t_dp_cmd o_cmd,
    output logic              o_busy,
    output logic              o_done
);

    prrts_pkg::t_state r_state, n_state;

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prrts_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_done  = 1'b0;
        case (r_state)
            prrts_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = prrts_pkg::S_EXEC;
                end
            end
            prrts_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.opcode == prrts_pkg::OP_TICK && i_sts.started) begin
                    n_state = prrts_pkg::S_SCAN_RD;
                end else if (i_sts.opcode == prrts_pkg::OP_CONTEXT) begin
                    n_state = prrts_pkg::S_CTX_WR;
                end else begin
                    n_state = prrts_pkg::S_DONE;
                end
            end
            prrts_pkg::S_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = prrts_pkg::S_SCAN_CHK;
            end
            prrts_pkg::S_SCAN_CHK: begin
                o_cmd.scan_chk = 1'b1;
                n_state = i_sts.scan_more ? prrts_pkg::S_SCAN_RD : prrts_pkg::S_DONE;
            end
            prrts_pkg::S_CTX_WR: begin
                o_cmd.ctx_wr = 1'b1;
                n_state = i_sts.started ? prrts_pkg::S_CTX_RUN : prrts_pkg::S_DONE;
            end
            prrts_pkg::S_CTX_RUN: begin
                o_cmd.ctx_run = 1'b1;
                n_state       = prrts_pkg::S_DONE;
            end
            prrts_pkg::S_DONE: begin
                o_done  = 1'b1;
                n_state = prrts_pkg::S_IDLE;
            end
            default: begin
                n_state = prrts_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: src/prrts_dpath.sv
// ----------------------------------------------------------------------------
// prrts_dpath
// Task table, slot memories, counters and scheduler registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prrts_dpath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  prrts_pkg::t_dp_cmd   i_cmd,
    input  prrts_pkg::t_sched_in i_item,
    output prrts_pkg::t_dp_sts   o_sts,
    output prrts_pkg::t_sched_out o_result
);

    localparam int RW = prrts_pkg::ROW_W;
    localparam int SW = prrts_pkg::SLOT_W;
    localparam int PW = prrts_pkg::POS_W;
    localparam int CW = prrts_pkg::CNT_W;
    localparam int NP = prrts_pkg::NUM_PRIORITIES;
    localparam int NS = prrts_pkg::NSLOTS;
    localparam int MT = prrts_pkg::MAX_TASKS;

    // memories
    logic [1:0]  slot_mem  [NS];
    logic [31:0] stack_mem [NS];

    logic [NS-1:0]  r_slot_vld;
    logic [1:0]     r_slot_rd;
    logic           r_slot_rv;
    logic [31:0]    r_stk_rd;

    logic [RW-1:0]  r_task_row  [MT];
    logic [SW-1:0]  r_task_slot [MT];
    logic [CW-1:0]  r_slots_used [NP];
    logic [CW-1:0]  r_active     [NP];
    logic [prrts_pkg::TC_W-1:0] r_tasks;

    logic [RW-1:0]  r_cur_row, r_next_row;
    logic [SW-1:0]  r_cur_idx, r_next_idx;
    logic           r_started, r_switch;
    logic [31:0]    r_tick_count;

    logic [RW-1:0]  r_scan_row;
    logic [SW-1:0]  r_scan_idx;
    logic [CW-1:0]  r_scan_n, r_scan_k;

    prrts_pkg::t_sched_in  r_item;
    prrts_pkg::t_sched_out r_res;

    // decoded item
    logic [RW-1:0]  prio;
    logic           prio_ok;
    logic [prrts_pkg::TASK_IW-1:0] tix;
    logic           task_ok;
    logic [RW-1:0]  t_row;
    logic [SW-1:0]  t_slot;
    logic [RW-1:0]  pick_row;
    logic [CW-1:0]  pick_n;
    logic [CW:0]    init_inc, scan_inc;
    logic [SW-1:0]  init_idx, scan_nidx;
    logic [PW-1:0]  p_out, p_in, slot_raddr, stk_raddr;
    logic [1:0]     slot_eff;
    logic           scan_more;

    logic           slot_we;
    logic [PW-1:0]  slot_waddr;
    logic [1:0]     slot_wdata;
    logic           stk_we;
    logic [PW-1:0]  stk_waddr;

    assign prio    = r_item.priority_req[RW-1:0];
    assign prio_ok = (32'(r_item.priority_req) < 32'(NP));
    assign tix     = prrts_pkg::TASK_IW'(r_item.task_number);
    assign task_ok = (32'(r_item.task_number) < 32'(r_tasks));
    assign t_row   = r_task_row[tix];
    assign t_slot  = r_task_slot[tix];
    assign p_out   = prrts_pkg::f_pos(r_cur_row, r_cur_idx);
    assign p_in    = prrts_pkg::f_pos(r_next_row, r_next_idx);
    assign slot_eff = r_slot_rv ? r_slot_rd : prrts_pkg::ST_EMPTY;

    // pick most urgent active row, else idle row
    always_comb begin
        pick_row = RW'(prrts_pkg::IDLE_ROW);
        for (int r = NP - 1; r >= 0; r--) begin
            if (r_active[r] != '0) begin
                pick_row = RW'(r);
            end
        end
    end

    // first slot after the current one, and scan advance
    always_comb begin
        pick_n    = r_slots_used[pick_row];
        init_inc  = (CW+1)'(r_next_idx) + (CW+1)'(1);
        init_idx  = (init_inc >= (CW+1)'(pick_n)) ? '0 : init_inc[SW-1:0];
        scan_inc  = (CW+1)'(r_scan_idx) + (CW+1)'(1);
        scan_nidx = (scan_inc >= (CW+1)'(r_scan_n)) ? '0 : scan_inc[SW-1:0];
        scan_more = (r_scan_k < r_scan_n) && (slot_eff == prrts_pkg::ST_BLOCKED);
    end

    // read addresses
    always_comb begin
        slot_raddr = i_cmd.scan_rd ? prrts_pkg::f_pos(r_scan_row, r_scan_idx) : p_out;
        stk_raddr  = r_started ? p_in : prrts_pkg::f_pos(r_cur_row, '0);
    end

    // write ports
    always_comb begin
        slot_we    = 1'b0;
        slot_waddr = prrts_pkg::f_pos(t_row, t_slot);
        slot_wdata = prrts_pkg::ST_READY;
        stk_we     = 1'b0;
        stk_waddr  = p_out;
        if (i_cmd.exec && r_item.opcode == prrts_pkg::OP_CREATE) begin
            if (prio_ok && 32'(r_tasks) < 32'(MT)
                    && 32'(r_slots_used[prio]) < 32'(prrts_pkg::SLOTS_PER_PRIORITY)) begin
                slot_we    = 1'b1;
                slot_waddr = prrts_pkg::f_pos(prio, r_slots_used[prio][SW-1:0]);
                stk_we     = 1'b1;
                stk_waddr  = slot_waddr;
            end
        end else if (i_cmd.exec && (r_item.opcode == prrts_pkg::OP_BLOCK
                                    || r_item.opcode == prrts_pkg::OP_UNBLOCK)) begin
            slot_we    = task_ok;
            slot_wdata = (r_item.opcode == prrts_pkg::OP_BLOCK) ? prrts_pkg::ST_BLOCKED
                                                                 : prrts_pkg::ST_READY;
        end else if (i_cmd.ctx_wr && r_started) begin
            stk_we     = 1'b1;
            slot_waddr = p_out;
            slot_we    = (slot_eff == prrts_pkg::ST_RUNNING);
        end else if (i_cmd.ctx_run) begin
            slot_we    = 1'b1;
            slot_waddr = p_in;
            slot_wdata = prrts_pkg::ST_RUNNING;
        end
    end

    // memory access
    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        if (stk_we) begin
            stack_mem[stk_waddr] <= r_item.task_sp;
        end
        r_slot_rd <= slot_mem[slot_raddr];
        r_slot_rv <= r_slot_vld[slot_raddr];
        r_stk_rd  <= stack_mem[stk_raddr];
    end

    // slot valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_vld <= '0;
        end else if (slot_we) begin
            r_slot_vld[slot_waddr] <= 1'b1;
        end
    end

    // capture item, build result, scan registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
            r_res  <= '0;
        end
        if (i_cmd.exec) begin
            case (r_item.opcode)
                prrts_pkg::OP_CREATE: begin
                    if (slot_we) begin
                        r_task_row[r_tasks[prrts_pkg::TASK_IW-1:0]]  <= prio;
                        r_task_slot[r_tasks[prrts_pkg::TASK_IW-1:0]] <= r_slots_used[prio][SW-1:0];
                        r_res.assigned_task <= 4'(r_tasks);
                    end else begin
                        r_res.status <= 1'b1;
                    end
                end
                prrts_pkg::OP_BLOCK, prrts_pkg::OP_UNBLOCK: begin
                    r_res.status <= !task_ok;
                end
                prrts_pkg::OP_TICK: begin
                    r_res.switch_needed <= r_switch;
                    r_scan_row <= pick_row;
                    r_scan_n   <= pick_n;
                    r_scan_idx <= init_idx;
                    r_scan_k   <= CW'(1);
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.scan_chk && scan_more) begin
            r_scan_idx <= scan_nidx;
            r_scan_k   <= r_scan_k + CW'(1);
        end
        if (i_cmd.scan_chk && !scan_more) begin
            if (slot_eff == prrts_pkg::ST_RUNNING) begin
                r_res.switch_needed <= 1'b0;
            end else if (slot_eff != prrts_pkg::ST_EMPTY) begin
                r_res.switch_needed <= 1'b1;
            end else begin
                r_res.switch_needed <= r_switch;
            end
        end
        if (i_cmd.ctx_wr) begin
            r_res.next_sp <= (r_started && p_out == p_in) ? r_item.task_sp : r_stk_rd;
        end
    end

    // scheduler control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tasks      <= '0;
            r_cur_row    <= '0;
            r_next_row   <= '0;
            r_cur_idx    <= '0;
            r_next_idx   <= '0;
            r_started    <= 1'b0;
            r_switch     <= 1'b1;
            r_tick_count <= '0;
            for (int r = 0; r < NP; r++) begin
                r_slots_used[r] <= '0;
                r_active[r]     <= '0;
            end
        end else begin
            if (i_cmd.exec) begin
                case (r_item.opcode)
                    prrts_pkg::OP_CREATE: begin
                        if (slot_we) begin
                            r_active[prio]     <= r_active[prio] + CW'(1);
                            r_slots_used[prio] <= r_slots_used[prio] + CW'(1);
                            r_tasks            <= r_tasks + prrts_pkg::TC_W'(1);
                        end
                    end
                    prrts_pkg::OP_BLOCK: begin
                        if (task_ok && r_active[t_row] != '0) begin
                            r_active[t_row] <= r_active[t_row] - CW'(1);
                        end
                    end
                    prrts_pkg::OP_UNBLOCK: begin
                        if (task_ok && r_active[t_row] < r_slots_used[t_row]) begin
                            r_active[t_row] <= r_active[t_row] + CW'(1);
                        end
                    end
                    prrts_pkg::OP_TICK: begin
                        r_cur_row    <= r_next_row;
                        r_next_row   <= pick_row;
                        r_tick_count <= r_tick_count + 32'd1;
                        if (r_started) begin
                            r_cur_idx <= r_next_idx;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            // close the slot search
            if (i_cmd.scan_chk && !scan_more) begin
                r_next_idx <= r_scan_idx;
                if (slot_eff == prrts_pkg::ST_RUNNING) begin
                    r_switch <= 1'b0;
                end else if (slot_eff != prrts_pkg::ST_EMPTY) begin
                    r_switch <= 1'b1;
                end
            end
            // first context starts the scheduler at slot 0
            if (i_cmd.ctx_wr && !r_started) begin
                r_next_idx <= '0;
                r_started  <= 1'b1;
            end
        end
    end

    assign o_sts.opcode    = r_item.opcode;
    assign o_sts.started   = r_started;
    assign o_sts.scan_more = scan_more;
    assign o_result        = r_res;

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the priority round-robin task scheduler.
// A directed table covers reset behavior, bad operations and a full row;
// random traffic then exercises create, block, unblock, tick and context
// switches. Results are checked per field against the predictor or a typed row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import prrts_pkg::*;

    localparam int N_RANDOM = 1130;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic       typed;
        t_sched_in  cmd;
        t_sched_out res;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    t_sched_in  i_cmd;
    logic       busy;
    logic       o_done;
    t_sched_out o_result;

    // scheduler mirror
    t_slot_st    slot_st [NSLOTS];
    logic [31:0] stack_tbl [NSLOTS];
    logic        stack_ok [NSLOTS];
    int          row_of [MAX_TASKS];
    int          slot_of [MAX_TASKS];
    int          n_tasks;
    int          used [NUM_PRIORITIES];
    int          active [NUM_PRIORITIES];
    int          cur_row, nxt_row, cur_idx, nxt_idx;
    logic        running;
    logic        sw_flag;

    t_sched_out  pending_q [$];
    t_row        dir_tbl [$];
    int          n_errors;

    priority_round_robin_task_scheduler_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int slot_pos(int row, int slot);
        return row * SLOTS_PER_PRIORITY + slot;
    endfunction

    // Advance the mirror by one transaction and return its result.
    function automatic t_sched_out schedule_step(t_sched_in c);
        t_sched_out r;
        int row, n, idx, p, q;
        r = '0;
        case (c.opcode)
            OP_CREATE: begin
                if (c.priority_req >= NUM_PRIORITIES || n_tasks >= MAX_TASKS ||
                    used[c.priority_req] >= SLOTS_PER_PRIORITY) begin
                    r.status = 1'b1;
                end else begin
                    row = c.priority_req;
                    p = slot_pos(row, used[row]);
                    slot_st[p] = ST_READY;
                    stack_tbl[p] = c.task_sp;
                    stack_ok[p] = 1'b1;
                    row_of[n_tasks] = row;
                    slot_of[n_tasks] = used[row];
                    active[row]++;
                    used[row]++;
                    r.assigned_task = 4'(n_tasks);
                    n_tasks++;
                end
            end
            OP_BLOCK, OP_UNBLOCK: begin
                if (c.task_number >= n_tasks) begin
                    r.status = 1'b1;
                end else begin
                    row = row_of[c.task_number];
                    p = slot_pos(row, slot_of[c.task_number]);
                    if (c.opcode == OP_BLOCK) begin
                        slot_st[p] = ST_BLOCKED;
                        if (active[row] > 0) active[row]--;
                    end else begin
                        slot_st[p] = ST_READY;
                        if (active[row] < used[row]) active[row]++;
                    end
                end
            end
            OP_TICK: begin
                cur_row = nxt_row;
                row = IDLE_ROW;
                for (int k = NUM_PRIORITIES - 1; k >= 0; k--)
                    if (active[k] != 0) row = k;
                nxt_row = row;
                if (running) begin
                    cur_idx = nxt_idx;
                    n = used[row];
                    idx = cur_idx + 1;
                    if (idx >= n) idx = 0;
                    // one pass at most, skip blocked slots
                    for (int k = 1; k < n; k++) begin
                        if (slot_st[slot_pos(row, idx)] != ST_BLOCKED) break;
                        idx++;
                        if (idx >= n) idx = 0;
                    end
                    nxt_idx = idx;
                    p = slot_pos(row, idx);
                    if (slot_st[p] == ST_RUNNING) sw_flag = 1'b0;
                    else if (slot_st[p] != ST_EMPTY) sw_flag = 1'b1;
                end
                r.switch_needed = sw_flag;
            end
            OP_CONTEXT: begin
                if (running) begin
                    p = slot_pos(cur_row, cur_idx);
                    q = slot_pos(nxt_row, nxt_idx);
                    stack_tbl[p] = c.task_sp;
                    stack_ok[p] = 1'b1;
                    r.next_sp = stack_tbl[q];
                    if (slot_st[p] == ST_RUNNING) slot_st[p] = ST_READY;
                    slot_st[q] = ST_RUNNING;
                end else begin
                    r.next_sp = stack_tbl[slot_pos(cur_row, 0)];
                    nxt_idx = 0;
                    running = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // True when a context transaction would read a stack entry never written.
    function automatic logic reads_unwritten();
        int p, q;
        if (!running) return !stack_ok[slot_pos(cur_row, 0)];
        p = slot_pos(cur_row, cur_idx);
        q = slot_pos(nxt_row, nxt_idx);
        return !(stack_ok[q] || p == q);
    endfunction

    task automatic add_row(logic typed, logic [2:0] op, logic [3:0] tn,
                           logic [2:0] pr, logic [31:0] sp, t_sched_out res);
        t_row e;
        e.typed = typed;
        e.cmd = '{opcode: op, task_number: tn, priority_req: pr, task_sp: sp};
        e.res = res;
        dir_tbl.push_back(e);
    endtask

    // Drive one transaction at the falling edge and book its expectation.
    task automatic send(t_sched_in c, logic typed, t_sched_out res, logic idle_ok);
        t_sched_out pred;
        while (idle_ok && $urandom_range(99) < 31) @(negedge i_clk);
        while (busy) @(negedge i_clk);
        // keep context reads on written stack entries
        if (c.opcode == OP_CONTEXT && reads_unwritten()) c.opcode = OP_TICK;
        pred = schedule_step(c);
        pending_q.push_back(typed ? res : pred);
        start = 1'b1;
        i_cmd = c;
        @(negedge i_clk);
        start = 1'b0;
    endtask

    // Check each result against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_q.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_SHOWN)
                    $display("unexpected result %h", o_result);
            end else begin
                t_sched_out e;
                e = pending_q.pop_front();
                if (o_result.next_sp != e.next_sp ||
                    o_result.switch_needed != e.switch_needed ||
                    o_result.assigned_task != e.assigned_task ||
                    o_result.status != e.status) begin
                    n_errors++;
                    if (n_errors <= MAX_SHOWN)
                        $display({"mismatch: exp sp=%h sw=%b task=%0d st=%b, ",
                                  "got sp=%h sw=%b task=%0d st=%b"},
                                 e.next_sp, e.switch_needed, e.assigned_task,
                                 e.status, o_result.next_sp,
                                 o_result.switch_needed, o_result.assigned_task,
                                 o_result.status);
                end
            end
        end
    end

    initial begin
        t_sched_in  c;
        t_sched_out z, full;
        t_sched_out tick1;
        int waited;
        logic [2:0] op;

        start = 1'b0;
        i_cmd = '0;
        i_rst_n = 1'b0;
        n_errors = 0;
        n_tasks = 0;
        cur_row = 0; nxt_row = 0; cur_idx = 0; nxt_idx = 0;
        running = 1'b0;
        sw_flag = 1'b1;
        for (int i = 0; i < NSLOTS; i++) begin
            slot_st[i] = ST_EMPTY;
            stack_tbl[i] = '0;
            stack_ok[i] = 1'b0;
        end
        for (int i = 0; i < NUM_PRIORITIES; i++) begin
            used[i] = 0;
            active[i] = 0;
        end
        z = '0;
        full = '0;
        full.status = 1'b1;
        tick1 = '0;
        tick1.switch_needed = 1'b1;

        // directed table: reset state, bad operations, extremes, full row
        add_row(1, 3'd5, 4'd15, 3'd7, 32'hFFFF_FFFF, z);
        add_row(1, 3'd6, 4'd0, 3'd0, 32'h0, z);
        add_row(1, 3'd7, 4'd9, 3'd2, 32'hA5A5_5A5A, z);
        add_row(1, OP_BLOCK, 4'd3, 3'd0, 32'h0, full);
        add_row(1, OP_UNBLOCK, 4'd15, 3'd0, 32'h0, full);
        add_row(1, OP_TICK, 4'd0, 3'd0, 32'h0, tick1);
        add_row(1, OP_CREATE, 4'd0, 3'd5, 32'h1234, full);
        add_row(1, OP_CREATE, 4'd0, 3'd7, 32'h1234, full);
        add_row(1, OP_CREATE, 4'd0, 3'd0, 32'h0, z);
        for (int i = 0; i < SLOTS_PER_PRIORITY; i++)
            add_row(0, OP_CREATE, 4'd0, 3'd3, 32'h1000 * (i + 1), z);
        add_row(1, OP_CREATE, 4'd0, 3'd3, 32'hDEAD, full);
        add_row(0, OP_CREATE, 4'd0, 3'd4, 32'hFFFF_FFFF, z);
        add_row(0, OP_CONTEXT, 4'd0, 3'd0, 32'h5555_AAAA, z);
        add_row(0, OP_TICK, 4'd0, 3'd0, 32'h0, z);
        add_row(0, OP_CONTEXT, 4'd0, 3'd0, 32'hFFFF_FFFF, z);
        add_row(0, OP_BLOCK, 4'd0, 3'd0, 32'h0, z);
        add_row(0, OP_TICK, 4'd0, 3'd0, 32'h0, z);
        add_row(0, OP_UNBLOCK, 4'd0, 3'd0, 32'h0, z);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_tbl[i])
            send(dir_tbl[i].cmd, dir_tbl[i].typed, dir_tbl[i].res, 1'b1);

        // random traffic, with a stretch of back-to-back commands
        for (int i = 0; i < N_RANDOM; i++) begin
            case ($urandom_range(99)) inside
                [0:11]:  op = OP_CREATE;
                [12:33]: op = OP_BLOCK;
                [34:55]: op = OP_UNBLOCK;
                [56:79]: op = OP_TICK;
                [80:95]: op = OP_CONTEXT;
                default: op = 3'($urandom_range(7, 5));
            endcase
            c.opcode = op;
            c.task_number = 4'($urandom_range(15));
            c.priority_req = 3'($urandom_range(7));
            c.task_sp = $urandom();
            send(c, 1'b0, z, !(i >= 400 && i < 600));
        end

        // drain, then let the block settle
        waited = 0;
        while (pending_q.size() != 0 && waited < 10000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (40) @(posedge i_clk);
        if (n_errors == 0 && pending_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+src
src/prrts_pkg.sv
src/prrts_ctrl.sv
src/prrts_dpath.sv
src/priority_round_robin_task_scheduler_unit.sv
verif/tb.sv
